[src/epi_pkg.sv]
// Shared types and constants for the epipolar inlier test pipeline.
// Used by epi_line, epi_side and epipolar_inlier_test; no dependencies.
package epi_pkg;

    // field widths
    localparam int unsigned CW  = 32;   // matrix coefficient, signed Q2.30
    localparam int unsigned PW  = 16;   // point coordinate, signed Q12.4
    localparam int unsigned TW  = 24;   // squared threshold, unsigned Q16.8
    localparam int unsigned CNW = 16;   // inlier counter
    localparam int unsigned XW  = CW + PW;  // coefficient times coordinate
    localparam int unsigned LW  = 50;   // line coefficient, signed Q.34

    // pipeline depth: stage NST is the output register
    localparam int unsigned NST = 9;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAIR_A = 3'd0,
        CFG_PAIR_B = 3'd1,
        CFG_PAIR_C = 3'd2,
        CFG_PAIR_D = 3'd3,
        CFG_LAST   = 3'd4,
        CFG_LIMIT  = 3'd5
    } t_cfg_idx;

    typedef logic signed [CW-1:0] t_coef;
    typedef logic signed [LW-1:0] t_line;

    // per-stage load enables, bit k loads stage k
    typedef logic [NST:1] t_ld;

    typedef struct packed {
        logic signed [PW-1:0] y2;
        logic signed [PW-1:0] x2;
        logic signed [PW-1:0] y1;
        logic signed [PW-1:0] x1;
    } t_pts;

    typedef struct packed {
        t_line a;
        t_line b;
        t_line c;
    } t_abc;

endpackage

[src/epi_line.sv]
// Stages 1 and 2: forms both epipolar lines from the point pair and the matrix.
// Depends on epi_pkg.
module epi_line
    import epi_pkg::*;
(
    input  logic  i_clk,
    input  t_ld   i_ld,
    input  t_coef i_f [0:8],
    input  t_pts  i_pts,
    output t_abc  o_line1,   // line in image 1, from point 2
    output t_abc  o_line2,   // line in image 2, from point 1
    output t_pts  o_pts
);

    logic signed [XW-1:0] r_p [0:11];
    t_pts r_pts1;
    t_pts r_pts2;
    t_abc r_line1;
    t_abc r_line2;

    // stage 1: coefficient times coordinate products
    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_p[0]  <= i_f[0] * i_pts.x1;
            r_p[1]  <= i_f[1] * i_pts.y1;
            r_p[2]  <= i_f[3] * i_pts.x1;
            r_p[3]  <= i_f[4] * i_pts.y1;
            r_p[4]  <= i_f[6] * i_pts.x1;
            r_p[5]  <= i_f[7] * i_pts.y1;
            r_p[6]  <= i_f[0] * i_pts.x2;
            r_p[7]  <= i_f[3] * i_pts.y2;
            r_p[8]  <= i_f[1] * i_pts.x2;
            r_p[9]  <= i_f[4] * i_pts.y2;
            r_p[10] <= i_f[2] * i_pts.x2;
            r_p[11] <= i_f[5] * i_pts.y2;
            r_pts1  <= i_pts;
        end
    end

    // stage 2: three-term sums, constant term is the coefficient times one pixel
    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_line2.a <= LW'(r_p[0])  + LW'(r_p[1])  + (LW'(i_f[2]) <<< 4);
            r_line2.b <= LW'(r_p[2])  + LW'(r_p[3])  + (LW'(i_f[5]) <<< 4);
            r_line2.c <= LW'(r_p[4])  + LW'(r_p[5])  + (LW'(i_f[8]) <<< 4);
            r_line1.a <= LW'(r_p[6])  + LW'(r_p[7])  + (LW'(i_f[6]) <<< 4);
            r_line1.b <= LW'(r_p[8])  + LW'(r_p[9])  + (LW'(i_f[7]) <<< 4);
            r_line1.c <= LW'(r_p[10]) + LW'(r_p[11]) + (LW'(i_f[8]) <<< 4);
            r_pts2    <= r_pts1;
        end
    end

    assign o_line1 = r_line1;
    assign o_line2 = r_line2;
    assign o_pts   = r_pts2;

endmodule

[src/epi_side.sv]
// Stages 3 to 8: exact test d*d <= T*(a*a+b*b) for one point against one line.
// Wide products are built from 33-bit-or-smaller partial products. Depends on epi_pkg.
module epi_side
    import epi_pkg::*;
(
    input  logic                 i_clk,
    input  t_ld                  i_ld,
    input  t_abc                 i_line,
    input  logic signed [PW-1:0] i_px,
    input  logic signed [PW-1:0] i_py,
    input  logic [TW-1:0]        i_lim,
    output logic                 o_ok
);

    localparam int unsigned MW  = 48;          // |a|, |b| magnitude
    localparam int unsigned HW  = MW / 2;      // square split
    localparam int unsigned SPL = 25;          // split of a, b for the d products
    localparam int unsigned AHW = LW - SPL;
    localparam int unsigned NW  = 2 * MW + 1;  // a*a + b*b
    localparam int unsigned DW  = 66;          // d, signed
    localparam int unsigned DCW = DW / 3;      // d magnitude chunk
    localparam int unsigned RW  = NW + TW;     // threshold side
    localparam int unsigned QW  = 2 * DW;      // d*d

    // stage 3 operands
    logic [LW-1:0]          w_aabs;
    logic [LW-1:0]          w_babs;
    logic [MW-1:0]          w_am;
    logic [MW-1:0]          w_bm;
    logic signed [AHW-1:0]  w_ah;
    logic signed [AHW-1:0]  w_bh;
    logic signed [SPL:0]    w_al;
    logic signed [SPL:0]    w_bl;

    always_comb begin
        w_aabs = i_line.a[LW-1] ? -i_line.a : i_line.a;
        w_babs = i_line.b[LW-1] ? -i_line.b : i_line.b;
        w_am   = w_aabs[MW-1:0];
        w_bm   = w_babs[MW-1:0];
        w_ah   = i_line.a[LW-1:SPL];
        w_bh   = i_line.b[LW-1:SPL];
        w_al   = {1'b0, i_line.a[SPL-1:0]};
        w_bl   = {1'b0, i_line.b[SPL-1:0]};
    end

    // stage 3: square partials and d partials
    logic [2*HW-1:0]            r_ahh, r_ahl, r_all;
    logic [2*HW-1:0]            r_bhh, r_bhl, r_bll;
    logic signed [PW+AHW-1:0]   r_dah, r_dbh;
    logic signed [PW+SPL:0]     r_dal, r_dbl;
    t_line                      r_c3;

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_ahh <= w_am[MW-1:HW] * w_am[MW-1:HW];
            r_ahl <= w_am[MW-1:HW] * w_am[HW-1:0];
            r_all <= w_am[HW-1:0]  * w_am[HW-1:0];
            r_bhh <= w_bm[MW-1:HW] * w_bm[MW-1:HW];
            r_bhl <= w_bm[MW-1:HW] * w_bm[HW-1:0];
            r_bll <= w_bm[HW-1:0]  * w_bm[HW-1:0];
            r_dah <= i_px * w_ah;
            r_dal <= i_px * w_al;
            r_dbh <= i_py * w_bh;
            r_dbl <= i_py * w_bl;
            r_c3  <= i_line.c;
        end
    end

    // stage 4: norm and signed distance term
    logic [NW-1:0]        r_norm;
    logic signed [DW-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_norm <= (NW'(r_ahh) << MW) + (NW'(r_ahl) << (HW + 1)) + NW'(r_all)
                    + (NW'(r_bhh) << MW) + (NW'(r_bhl) << (HW + 1)) + NW'(r_bll);
            r_d    <= (DW'(r_dah) <<< SPL) + DW'(r_dal)
                    + (DW'(r_dbh) <<< SPL) + DW'(r_dbl)
                    + (DW'(r_c3) <<< 4);
        end
    end

    // stage 5: |d| and threshold partials over slices of the norm, 32, 32 and 33 bits wide
    logic [DW-1:0]          w_dabs;
    logic [DW-1:0]          r_dm;
    logic [32+TW-1:0]       r_r0, r_r1;
    logic [NW-64+TW-1:0]    r_r2;
    logic                   r_nz5;

    assign w_dabs = r_d[DW-1] ? -r_d : r_d;

    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r_dm  <= w_dabs;
            r_r0  <= r_norm[31:0]    * i_lim;
            r_r1  <= r_norm[63:32]   * i_lim;
            r_r2  <= r_norm[NW-1:64] * i_lim;
            r_nz5 <= |r_norm;
        end
    end

    // stage 6: d square partials, threshold side sum
    logic [2*DCW-1:0] r_q00, r_q11, r_q22, r_q01, r_q02, r_q12;
    logic [RW-1:0]    r_rhs6;
    logic             r_nz6;

    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_q00  <= r_dm[DCW-1:0]       * r_dm[DCW-1:0];
            r_q11  <= r_dm[2*DCW-1:DCW]   * r_dm[2*DCW-1:DCW];
            r_q22  <= r_dm[DW-1:2*DCW]    * r_dm[DW-1:2*DCW];
            r_q01  <= r_dm[DCW-1:0]       * r_dm[2*DCW-1:DCW];
            r_q02  <= r_dm[DCW-1:0]       * r_dm[DW-1:2*DCW];
            r_q12  <= r_dm[2*DCW-1:DCW]   * r_dm[DW-1:2*DCW];
            r_rhs6 <= RW'(r_r0) + (RW'(r_r1) << 32) + (RW'(r_r2) << 64);
            r_nz6  <= r_nz5;
        end
    end

    // stage 7: d*d sum, cross terms doubled by one extra shift
    logic [QW-1:0] r_dsq;
    logic [RW-1:0] r_rhs7;
    logic          r_nz7;

    always_ff @(posedge i_clk) begin
        if (i_ld[7]) begin
            r_dsq  <= QW'(r_q00)
                    + (QW'(r_q01) << (DCW + 1))
                    + (QW'(r_q11) << (2 * DCW))
                    + (QW'(r_q02) << (2 * DCW + 1))
                    + (QW'(r_q12) << (3 * DCW + 1))
                    + (QW'(r_q22) << (4 * DCW));
            r_rhs7 <= r_rhs6;
            r_nz7  <= r_nz6;
        end
    end

    // stage 8: compare; degenerate line fails
    logic r_ok;

    always_ff @(posedge i_clk) begin
        if (i_ld[8]) begin
            r_ok <= r_nz7 && (r_dsq <= QW'(r_rhs7));
        end
    end

    assign o_ok = r_ok;

endmodule

[src/epipolar_inlier_test.sv]
// Top level of the symmetric epipolar distance inlier check: config registers,
// stage valid/stall control, running inlier count. Depends on epi_pkg, epi_line, epi_side.
//
// One correspondence word enters per clock while the result stream is not stalled,
// and its result word passes eight arithmetic stages plus the output register;
// without stalls throughput is one word per cycle. The depth is set by the multiplier
// partial-product pipeline in epi_side, which builds the exact 132-bit squared
// distance and 121-bit threshold products from 33-bit-or-smaller multipliers.
// Each stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so a stalled output only backs up the pipeline as far as
// it is full. Matrix and threshold registers may be written only while no word
// is in flight. The inlier count saturates at 65535 and clears after a word
// with tlast set; that word carries the final total of the set.
module epipolar_inlier_test
    import epi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    // correspondence stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,    // first_x, first_y, second_x, second_y
    input  logic        i_s_tlast,    // set_end
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,    // is_inlier, inlier_total, 7 zero bits
    output logic        o_m_tlast     // set_done
);

    // configuration registers
    logic [63:0]   r_pair_a, r_pair_b, r_pair_c, r_pair_d;
    logic [CW-1:0] r_last;
    logic [TW-1:0] r_lim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_a <= '0;
            r_pair_b <= '0;
            r_pair_c <= '0;
            r_pair_d <= '0;
            r_last   <= CW'(32'h4000_0000);
            r_lim    <= TW'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_PAIR_A: r_pair_a <= i_cfg_data;
                CFG_PAIR_B: r_pair_b <= i_cfg_data;
                CFG_PAIR_C: r_pair_c <= i_cfg_data;
                CFG_PAIR_D: r_pair_d <= i_cfg_data;
                CFG_LAST:   r_last   <= i_cfg_data[CW-1:0];
                CFG_LIMIT:  r_lim    <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    t_coef w_f [0:8];

    assign w_f[0] = r_pair_a[31:0];
    assign w_f[1] = r_pair_a[63:32];
    assign w_f[2] = r_pair_b[31:0];
    assign w_f[3] = r_pair_b[63:32];
    assign w_f[4] = r_pair_c[31:0];
    assign w_f[5] = r_pair_c[63:32];
    assign w_f[6] = r_pair_d[31:0];
    assign w_f[7] = r_pair_d[63:32];
    assign w_f[8] = r_last;

    // stage load enables: a stage loads when empty or when its word moves on
    logic [NST:1] r_v;
    t_ld          w_ld;

    always_comb begin
        w_ld[NST] = !r_v[NST] || i_m_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            w_ld[k] = !r_v[k] || w_ld[k+1];
        end
    end

    assign o_s_tready = w_ld[1];

    // input unpack
    t_pts w_pts;

    assign w_pts.x1 = i_s_tdata[15:0];
    assign w_pts.y1 = i_s_tdata[31:16];
    assign w_pts.x2 = i_s_tdata[47:32];
    assign w_pts.y2 = i_s_tdata[63:48];

    // datapath
    t_abc w_line1;
    t_abc w_line2;
    t_pts w_pts2;
    logic w_ok1;
    logic w_ok2;
    logic w_ok;

    epi_line u_line (
        .i_clk   (i_clk),
        .i_ld    (w_ld),
        .i_f     (w_f),
        .i_pts   (w_pts),
        .o_line1 (w_line1),
        .o_line2 (w_line2),
        .o_pts   (w_pts2)
    );

    epi_side u_side1 (
        .i_clk  (i_clk),
        .i_ld   (w_ld),
        .i_line (w_line1),
        .i_px   (w_pts2.x1),
        .i_py   (w_pts2.y1),
        .i_lim  (r_lim),
        .o_ok   (w_ok1)
    );

    epi_side u_side2 (
        .i_clk  (i_clk),
        .i_ld   (w_ld),
        .i_line (w_line2),
        .i_px   (w_pts2.x2),
        .i_py   (w_pts2.y2),
        .i_lim  (r_lim),
        .o_ok   (w_ok2)
    );

    assign w_ok = w_ok1 && w_ok2;

    // end-of-set flag travels beside the datapath
    logic [NST-1:1] r_end;

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_end[1] <= i_s_tlast;
        end
        for (int k = 2; k < NST; k++) begin
            if (w_ld[k]) begin
                r_end[k] <= r_end[k-1];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[1]) begin
                r_v[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // running count, updated as a word enters the output register
    logic [CNW-1:0] r_cnt;
    logic [CNW-1:0] n_total;
    logic [CNW-1:0] r_out_total;
    logic           r_out_ok;
    logic           r_out_end;

    assign n_total = (w_ok && (r_cnt != {CNW{1'b1}})) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_ld[NST] && r_v[NST-1]) begin
            r_cnt <= r_end[NST-1] ? '0 : n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[NST]) begin
            r_out_ok    <= w_ok;
            r_out_total <= n_total;
            r_out_end   <= r_end[NST-1];
        end
    end

    assign o_m_tvalid = r_v[NST];
    assign o_m_tdata  = {7'd0, r_out_total, r_out_ok};
    assign o_m_tlast  = r_out_end;

    // checks
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld[NST] && r_v[NST-1] && r_end[NST-1]) |=> (r_cnt == '0))
        else $error("inlier count not cleared after end of set");

    a_hold_on_outlier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld[NST] && r_v[NST-1] && !w_ok) |=> (r_out_total == $past(r_cnt)))
        else $error("total changed on an outlier");

    a_inlier_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_ok) |-> (r_out_total != '0))
        else $error("inlier reported with zero total");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[1] |-> o_s_tready)
        else $error("input stalled while first stage is empty");

endmodule
